// File: hdl/pbrd_pkg.sv
// ----------------------------------------------------------------------------
// pbrd_pkg - pulse beat rate detector shared definitions
// Widths, reset values, register indexes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package pbrd_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int SAMPLE_W       = 10;
  localparam int RATE_W         = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [RATE_W-1:0]   MINUTE_MS         = 16'd60000;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET   = 10'd550;
  localparam logic [15:0]         REFRACTORY_RESET  = 16'd200;
  localparam logic [15:0]         RATE_LIMIT_RESET  = 16'd72;

  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_INDEX_W-1:0] REG_BEAT_LEVEL    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REFRACTORY_MS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_LIMIT    = 2'd2;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAPSED,
    S_DECIDE,
    S_DIVIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic tick;
    logic load_sample;
    logic calc_elapsed;
    logic decide;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic big;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

// File: hdl/pulse_beat_rate_detector.sv
// ----------------------------------------------------------------------------
// pulse_beat_rate_detector - heartbeat detector with refractory window
// A tick word advances the millisecond counter. A sample word produces one
// result word; a new beat triggers the 16-step restoring divider for
// 60000 / elapsed time unless more than 60000 ms have passed. Ticks are
// accepted while a finished result still waits on the output register.
// ----------------------------------------------------------------------------
module pulse_beat_rate_detector #(
  parameter int TIME_WIDTH = pbrd_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [pbrd_pkg::SAMPLE_W-1:0]    sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             beat,
  output logic [pbrd_pkg::RATE_W-1:0]      rate,
  output logic                             high_rate,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbrd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pbrd_pkg::cmd_t    cmd;
  pbrd_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  pbrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbrd_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sample    (sample),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .beat      (beat),
    .rate      (rate),
    .high_rate (high_rate)
  );

endmodule

// File: hdl/pbrd_ctrl.sv
// ----------------------------------------------------------------------------
// pbrd_ctrl - beat detector sequencer
// Accepts input words, steps the datapath through elapsed-time check,
// beat decision, rate division and result load.
// ----------------------------------------------------------------------------
module pbrd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              req_type,
  output logic              in_ready,
  input  pbrd_pkg::status_t stat,
  output pbrd_pkg::cmd_t    cmd
);

  pbrd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbrd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      pbrd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == pbrd_pkg::REQ_SAMPLE) begin
            cmd.load_sample = 1'b1;
            state_next      = pbrd_pkg::S_ELAPSED;
          end else begin
            cmd.tick = 1'b1;
          end
        end
      end
      pbrd_pkg::S_ELAPSED: begin
        cmd.calc_elapsed = 1'b1;
        state_next       = pbrd_pkg::S_DECIDE;
      end
      pbrd_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.hit && !stat.big) begin
          cmd.div_start = 1'b1;
          state_next    = pbrd_pkg::S_DIVIDE;
        end else begin
          state_next = pbrd_pkg::S_DONE;
        end
      end
      pbrd_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = pbrd_pkg::S_DONE;
        end
      end
      pbrd_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = pbrd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pbrd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/pbrd_datapath.sv
// ----------------------------------------------------------------------------
// pbrd_datapath - beat detector datapath
// Time counter, last beat time, config registers, elapsed-time compare,
// restoring rate divider and the output word register.
// ----------------------------------------------------------------------------
module pbrd_datapath #(
  parameter int TIME_WIDTH = pbrd_pkg::TIME_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pbrd_pkg::cmd_t                     cmd,
  output pbrd_pkg::status_t                  stat,
  input  logic [pbrd_pkg::SAMPLE_W-1:0]      sample,
  input  logic                               cfg_valid,
  input  logic [pbrd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               beat,
  output logic [pbrd_pkg::RATE_W-1:0]        rate,
  output logic                               high_rate
);

  logic [pbrd_pkg::SAMPLE_W-1:0]  beat_level;
  logic [15:0]                    refractory_ms;
  logic [15:0]                    rate_limit;

  logic [TIME_WIDTH-1:0]          time_ms;
  logic [TIME_WIDTH-1:0]          last_beat_ms;
  logic [TIME_WIDTH-1:0]          elapsed;
  logic [pbrd_pkg::RATE_W-1:0]    rate_reg;
  logic [pbrd_pkg::SAMPLE_W-1:0]  sample_q;
  logic                           hit_q;

  logic [pbrd_pkg::RATE_W-1:0]    divisor;
  logic [pbrd_pkg::RATE_W-1:0]    quo;
  logic [pbrd_pkg::RATE_W-1:0]    rem;
  logic [pbrd_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [pbrd_pkg::RATE_W:0]      shifted;
  logic [pbrd_pkg::RATE_W:0]      trial;
  logic                           q_bit;
  logic [pbrd_pkg::RATE_W-1:0]    quo_next;

  always_comb begin
    shifted  = {rem, quo[pbrd_pkg::RATE_W-1]};
    trial    = shifted - {1'b0, divisor};
    q_bit    = (shifted >= {1'b0, divisor});
    quo_next = {quo[pbrd_pkg::RATE_W-2:0], q_bit};
  end

  always_comb begin
    stat.hit      = (sample_q > beat_level) && (elapsed > TIME_WIDTH'(refractory_ms));
    stat.big      = (elapsed > TIME_WIDTH'(pbrd_pkg::MINUTE_MS));
    stat.div_last = (div_cnt == pbrd_pkg::DIV_CNT_W'(pbrd_pkg::DIV_STEPS - 1));
    stat.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_level    <= pbrd_pkg::THRESHOLD_RESET;
      refractory_ms <= pbrd_pkg::REFRACTORY_RESET;
      rate_limit    <= pbrd_pkg::RATE_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pbrd_pkg::REG_BEAT_LEVEL:    beat_level    <= cfg_data[pbrd_pkg::SAMPLE_W-1:0];
        pbrd_pkg::REG_REFRACTORY_MS: refractory_ms <= cfg_data;
        pbrd_pkg::REG_RATE_LIMIT:    rate_limit    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms      <= '0;
      last_beat_ms <= '0;
      rate_reg     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.tick) begin
        time_ms <= time_ms + TIME_WIDTH'(1);
      end
      if (cmd.decide && stat.hit) begin
        last_beat_ms <= time_ms;
        if (stat.big) begin
          rate_reg <= '0;
        end
      end
      if (cmd.div_step && stat.div_last) begin
        rate_reg <= quo_next;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample_q <= sample;
    end
    if (cmd.calc_elapsed) begin
      elapsed <= time_ms - last_beat_ms;
    end
    if (cmd.decide) begin
      hit_q <= stat.hit;
    end
    if (cmd.div_start) begin
      divisor <= elapsed[pbrd_pkg::RATE_W-1:0];
      quo     <= pbrd_pkg::MINUTE_MS;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      quo     <= quo_next;
      rem     <= q_bit ? trial[pbrd_pkg::RATE_W-1:0] : shifted[pbrd_pkg::RATE_W-1:0];
      div_cnt <= div_cnt + pbrd_pkg::DIV_CNT_W'(1);
    end
    if (cmd.out_load) begin
      beat      <= hit_q;
      rate      <= rate_reg;
      high_rate <= (rate_reg >= rate_limit);
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && stat.div_last |=> rate_reg != '0)
    else $error("divider produced zero rate");

  a_beat_time: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && stat.hit |=> last_beat_ms == $past(time_ms))
    else $error("last beat time not captured");

  a_tick_adv: assert property (@(posedge clk) disable iff (rst)
    cmd.tick |=> time_ms == $past(time_ms) + TIME_WIDTH'(1))
    else $error("time counter did not advance");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.out_load && stat.out_busy))
    else $error("output word overwritten while pending");

endmodule

// File: tb/pulse_beat_rate_detector_tb.sv
// ----------------------------------------------------------------------------
// pulse_beat_rate_detector_tb - self-checking bench for the beat detector
// Drives tick and sample words plus register writes through valid/ready
// channels with random gaps and stalls. An in-bench tracker of time, last
// beat and rate predicts each result word no table row fixes. A directed
// table runs first, then random phases under several register settings.
// ----------------------------------------------------------------------------
module pulse_beat_rate_detector_tb;
  import pbrd_pkg::*;

  localparam int TW          = TIME_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 140;

  typedef struct packed {
    logic              beat;
    logic [RATE_W-1:0] rate;
    logic              high_rate;
  } rate_word_t;

  typedef struct packed {
    logic                   cfg_row;
    logic [CFG_INDEX_W-1:0] idx;
    logic                   kind;
    logic [15:0]            val;
    logic [15:0]            reps;
    logic                   typed;
    rate_word_t             want;
  } plan_row_t;

  localparam rate_word_t NO_WORD = '0;
  localparam int PLAN_ROWS = 28;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1023, 16'd1,   1'b1, '{1'b0, 16'd0, 1'b0}},
    '{1'b1, REG_RATE_LIMIT,    REQ_TICK,   16'd0,    16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1023, 16'd1,   1'b1, '{1'b0, 16'd0, 1'b1}},
    '{1'b1, REG_RATE_LIMIT,    REQ_TICK,   16'd72,   16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_TICK,   16'd1023, 16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_TICK,   16'd0,    16'd199, 1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1023, 16'd1,   1'b1, '{1'b0, 16'd0, 1'b0}},
    '{1'b0, REG_BEAT_LEVEL,    REQ_TICK,   16'd512,  16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd550,  16'd1,   1'b1, '{1'b0, 16'd0, 1'b0}},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd551,  16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1023, 16'd1,   1'b0, NO_WORD},
    '{1'b1, REG_REFRACTORY_MS, REQ_TICK,   16'd0,    16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_TICK,   16'd0,    16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1023, 16'd1,   1'b1, '{1'b1, 16'd60000, 1'b1}},
    '{1'b1, REG_RATE_LIMIT,    REQ_TICK,   16'd60000, 16'd1,  1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_TICK,   16'd0,    16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1023, 16'd1,   1'b1, '{1'b1, 16'd60000, 1'b1}},
    '{1'b1, REG_RATE_LIMIT,    REQ_TICK,   16'd65535, 16'd1,  1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1023, 16'd1,   1'b1, '{1'b0, 16'd60000, 1'b0}},
    '{1'b1, REG_BEAT_LEVEL,    REQ_TICK,   16'd1023, 16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_TICK,   16'd0,    16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1023, 16'd1,   1'b1, '{1'b0, 16'd60000, 1'b0}},
    '{1'b1, REG_BEAT_LEVEL,    REQ_TICK,   16'd0,    16'd1,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd0,    16'd1,   1'b1, '{1'b0, 16'd60000, 1'b0}},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1,    16'd1,   1'b1, '{1'b1, 16'd60000, 1'b0}},
    '{1'b1, REG_REFRACTORY_MS, REQ_TICK,   16'd65535, 16'd1,  1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_TICK,   16'd0,    16'd3,   1'b0, NO_WORD},
    '{1'b0, REG_BEAT_LEVEL,    REQ_SAMPLE, 16'd1023, 16'd1,   1'b0, NO_WORD}
  };

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   req_type;
  logic [SAMPLE_W-1:0]    sample;
  logic                   out_valid;
  logic                   out_ready;
  logic                   beat;
  logic [RATE_W-1:0]      rate;
  logic                   high_rate;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [SAMPLE_W-1:0] thr_cfg;
  logic [15:0]         refr_cfg;
  logic [15:0]         limit_cfg;
  logic [TW-1:0]       time_now;
  logic [TW-1:0]       last_beat;
  logic [RATE_W-1:0]   rate_now;

  rate_word_t pending_rates [$];
  rate_word_t head;
  int         errors;
  int         cycles;
  bit         quiet;
  bit         hold_req;

  pulse_beat_rate_detector dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .beat      (beat),
    .rate      (rate),
    .high_rate (high_rate),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic bit detect_beat(input logic kind, input logic [SAMPLE_W-1:0] smp,
                                     output rate_word_t res);
    logic [TW-1:0] elapsed;
    res = '0;
    if (kind == REQ_TICK) begin
      time_now = time_now + TW'(1);
      return 1'b0;
    end
    elapsed = time_now - last_beat;
    res.beat = (smp > thr_cfg) && (elapsed > TW'(refr_cfg));
    if (res.beat) begin
      rate_now  = RATE_W'(TW'(MINUTE_MS) / elapsed);
      last_beat = time_now;
    end
    res.rate      = rate_now;
    res.high_rate = (rate_now >= limit_cfg);
    return 1'b1;
  endfunction

  task automatic push_word(input logic kind, input logic [SAMPLE_W-1:0] smp,
                           input bit use_typed, input rate_word_t typed_word);
    int gap;
    int pick;
    rate_word_t res;
    gap = 0;
    if (!quiet) begin
      pick = $urandom_range(0, 99);
      if (pick >= 98) gap = $urandom_range(20, 60);
      else if (pick >= 92) gap = $urandom_range(4, 12);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    sample   <= smp;
    do @(posedge clk); while (!in_ready);
    if (detect_beat(kind, smp, res))
      pending_rates.push_back(use_typed ? typed_word : res);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rates.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BEAT_LEVEL:    thr_cfg = data[SAMPLE_W-1:0];
      REG_REFRACTORY_MS: refr_cfg = data;
      REG_RATE_LIMIT:    limit_cfg = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] thr, input logic [15:0] refr,
                           input logic [15:0] lim);
    settle();
    write_reg(REG_BEAT_LEVEL, thr);
    write_reg(REG_REFRACTORY_MS, refr);
    write_reg(REG_RATE_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_rates.size() == 0) begin
        $display("%0t: unexpected word: beat=%0d rate=%0d high_rate=%0d",
                 $time, beat, rate, high_rate);
        errors++;
      end else begin
        head = pending_rates.pop_front();
        if (beat !== head.beat) begin
          $display("%0t: beat mismatch: expected %0d, got %0d", $time, head.beat, beat);
          errors++;
        end
        if (rate !== head.rate) begin
          $display("%0t: rate mismatch: expected %0d, got %0d", $time, head.rate, rate);
          errors++;
        end
        if (high_rate !== head.high_rate) begin
          $display("%0t: high_rate mismatch: expected %0d, got %0d",
                   $time, head.high_rate, high_rate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall;
    int pick;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        pick = $urandom_range(0, 99);
        if (!quiet) begin
          if (pick >= 97) stall = $urandom_range(20, 60);
          else if (pick >= 90) stall = $urandom_range(4, 12);
          else if (pick >= 65) stall = $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin
    plan_row_t     row;
    int            sent;
    int            budget;
    int            n;
    int            span;
    int            pick;
    logic [SAMPLE_W-1:0] smp;
    logic [15:0]   thr;
    logic [15:0]   refr;
    logic [15:0]   lim;

    rst       = 1'b1;
    in_valid  = 1'b0;
    req_type  = REQ_TICK;
    sample    = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BEAT_LEVEL;
    cfg_data  = '0;
    errors    = 0;
    cycles    = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    thr_cfg   = THRESHOLD_RESET;
    refr_cfg  = REFRACTORY_RESET;
    limit_cfg = RATE_LIMIT_RESET;
    time_now  = '0;
    last_beat = '0;
    rate_now  = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = PLAN[i];
      if (row.cfg_row) begin
        settle();
        write_reg(row.idx, row.val);
        cfg_valid <= 1'b0;
      end else begin
        for (int k = 0; k < int'(row.reps); k++)
          push_word(row.kind, row.val[SAMPLE_W-1:0], row.typed, row.want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      budget = PHASE_WORDS;
      case (p)
        0: begin thr = 16'd0;    refr = 16'd0;     lim = 16'd0;     end
        1: begin thr = 16'd1023; refr = 16'd65535; lim = 16'd60000; budget = 60; end
        2: begin
          thr  = 16'(THRESHOLD_RESET);
          refr = REFRACTORY_RESET;
          lim  = RATE_LIMIT_RESET;
        end
        default: begin
          thr  = 16'($urandom_range(0, 1023));
          refr = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 300)
                                                 : $urandom_range(0, 40));
          lim  = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 60000)
                                                 : $urandom_range(0, 4000));
        end
      endcase
      configure(thr, refr, lim);
      quiet = (p == 0);
      if (p == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < budget) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          span = (refr_cfg > 16'd300) ? 300 : int'(refr_cfg);
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 600)
                                          : $urandom_range(0, span + 20);
          if (n > budget - sent - 1) n = budget - sent - 1;
          for (int k = 0; k < n; k++)
            push_word(REQ_TICK, SAMPLE_W'($urandom_range(0, 1023)), 1'b0, NO_WORD);
          if (thr_cfg == 10'd1023 || $urandom_range(0, 3) == 0)
            smp = SAMPLE_W'($urandom_range(0, 1023));
          else
            smp = SAMPLE_W'($urandom_range(int'(thr_cfg) + 1, 1023));
          push_word(REQ_SAMPLE, smp, 1'b0, NO_WORD);
          sent += n + 1;
        end else begin
          push_word(($urandom_range(0, 1) == 0) ? REQ_TICK : REQ_SAMPLE,
                    SAMPLE_W'($urandom_range(0, 1023)), 1'b0, NO_WORD);
          sent++;
        end
      end
    end

    settle();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
